// ===== rtl/wlti_pkg.sv =====
// Shared types, constants and breakpoint tables of the wideband lambda interpolator.
package wlti_pkg;

    // Field and register widths.
    localparam int MV_W       = 13;
    localparam int CUR_W      = 13;
    localparam int LAM_W      = 14;
    localparam int AFR_W      = 15;
    localparam int GAIN_W     = 16;
    localparam int SCALE_W    = 16;
    localparam int STOICH_W   = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAL_MV     = 3'd0,
        REG_AMP_GAIN   = 3'd1,
        REG_PUMP_SCALE = 3'd2,
        REG_NEWER      = 3'd3,
        REG_STOICH     = 3'd4
    } t_cfg_reg;

    // Reset values of the configuration registers.
    localparam logic [MV_W-1:0]     CAL_MV_RST     = 13'd1500;
    localparam logic [GAIN_W-1:0]   AMP_GAIN_RST   = 16'd3855;
    localparam logic [SCALE_W-1:0]  PUMP_SCALE_RST = 16'd4136;
    localparam logic                NEWER_RST      = 1'b0;
    localparam logic [STOICH_W-1:0] STOICH_RST     = 11'd1470;

    // Pump current arithmetic: Q0.16 times Q8.8 gives a 24-bit fraction.
    localparam int CUR_SHIFT = 24;
    localparam int CUR_LIMIT = 4000;
    localparam int UA_W      = 22;

    // Breakpoint tables, microamps against milli-lambda.
    localparam int OLD_N = 9;
    localparam int NEW_N = 24;

    localparam int OLD_CUR [OLD_N] = '{
        -1850, -1080, -760, -470, 0, 340, 680, 950, 1400
    };
    localparam int OLD_LAM [OLD_N] = '{
        700, 800, 850, 900, 1009, 1180, 1430, 1700, 2420
    };
    localparam int NEW_CUR [NEW_N] = '{
        -2000, -1602, -1243, -927, -800, -652, -405, -183, -106, -40, 0, 15,
        97, 193, 250, 329, 671, 938, 1150, 1385, 1700, 2000, 2150, 2250
    };
    localparam int NEW_LAM [NEW_N] = '{
        650, 700, 750, 800, 822, 850, 900, 950, 970, 990, 1003, 1010,
        1050, 1100, 1132, 1179, 1429, 1701, 1990, 2434, 3413, 5391, 7506, 10119
    };

    // Segment division: floor(2^DIV_K / span) for each segment, so that the
    // estimated quotient is never high and at most one below the true one.
    localparam int DIV_K   = 21;
    localparam int NUM_W   = 20;
    localparam int RECIP_W = 18;
    localparam int DX_W    = 10;
    localparam int DY_W    = 12;
    localparam int QUO_W   = 12;

    localparam int OLD_RECIP [OLD_N-1] = '{
        2723, 6553, 7231, 4462, 6168, 6168, 7767, 4660
    };
    localparam int NEW_RECIP [NEW_N-1] = '{
        5269, 5841, 6636, 16513, 14169, 8490, 9446, 27235, 31775, 52428,
        139810, 25575, 21845, 36792, 26546, 6132, 7854, 9892, 8924, 6657,
        6990, 13981, 20971
    };

    // Air-fuel ratio: divide by 1000 through a reciprocal scaled by 2^25.
    localparam int AFR_K     = 25;
    localparam int AFR_DIV   = 1000;
    localparam int AFR_ROUND = AFR_DIV / 2;
    localparam int AFR_RECIP = (1 << AFR_K) / AFR_DIV;
    localparam int AFR_MAX   = 32767;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [MV_W-1:0]     cal_mv;
        logic [GAIN_W-1:0]   amp_gain;
        logic [SCALE_W-1:0]  pump_scale;
        logic                newer;
        logic [STOICH_W-1:0] stoich;
    } t_cfg;

    // Result travelling from the interpolator to the ratio stage.
    typedef struct packed {
        logic signed [CUR_W-1:0] cur;
        logic [LAM_W-1:0]        lam;
        logic                    flag;
    } t_lam_item;

endpackage

// ===== rtl/wlti_in_if.sv =====
// Sample channel: one pump voltage per transaction.
interface wlti_in_if;
    logic                         valid;
    logic                         ready;
    logic [wlti_pkg::MV_W-1:0]    pump_millivolts;

    modport source (output valid, output pump_millivolts, input ready);
    modport sink   (input valid, input pump_millivolts, output ready);
endinterface

// ===== rtl/wlti_out_if.sv =====
// Result channel: pump current, lambda, ratio and range flag per transaction.
interface wlti_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [wlti_pkg::CUR_W-1:0]   pump_microamps;
    logic [wlti_pkg::LAM_W-1:0]          lambda_milli;
    logic [wlti_pkg::AFR_W-1:0]          afr_centi;
    logic                                out_of_table;

    modport source (output valid, output pump_microamps, output lambda_milli,
                    output afr_centi, output out_of_table, input ready);
    modport sink   (input valid, input pump_microamps, input lambda_milli,
                    input afr_centi, input out_of_table, output ready);
endinterface

// ===== rtl/wlti_current.sv =====
// Pump current: offset, two cascaded multiplies, rounding and saturation.
module wlti_current (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_up_valid,
    output logic                                o_up_ready,
    input  logic [wlti_pkg::MV_W-1:0]           i_mv,
    input  logic [wlti_pkg::MV_W-1:0]           i_cal_mv,
    input  logic [wlti_pkg::GAIN_W-1:0]         i_amp_gain,
    input  logic [wlti_pkg::SCALE_W-1:0]        i_pump_scale,
    output logic                                o_dn_valid,
    input  logic                                i_dn_ready,
    output logic signed [wlti_pkg::CUR_W-1:0]   o_cur
);
    localparam int STAGES  = 4;
    localparam int MV_W    = wlti_pkg::MV_W;
    localparam int CUR_W   = wlti_pkg::CUR_W;
    localparam int UA_W    = wlti_pkg::UA_W;
    localparam int P1_W    = wlti_pkg::MV_W + wlti_pkg::GAIN_W;
    localparam int P2_W    = P1_W + wlti_pkg::SCALE_W;
    localparam int SUM_W   = P2_W + 1;
    localparam int MAG_W   = CUR_W - 1;
    localparam logic [SUM_W-1:0] HALF   = SUM_W'(1) << (wlti_pkg::CUR_SHIFT - 1);
    localparam logic [UA_W-1:0]  LIMIT  = UA_W'(wlti_pkg::CUR_LIMIT);

    logic [STAGES-1:0] r_v;
    logic [STAGES-1:0] en;

    logic              r_neg0, r_neg1, r_neg2;
    logic [MV_W-1:0]   r_mag;
    logic [P1_W-1:0]   r_p1;
    logic [P2_W-1:0]   r_p2;
    logic [CUR_W-1:0]  r_cur;

    logic              n_neg;
    logic [MV_W-1:0]   n_mag;
    logic [SUM_W-1:0]  sum;
    logic [UA_W-1:0]   ua;
    logic [MAG_W-1:0]  ua_sat;
    logic [CUR_W-1:0]  n_cur;

    // A stage moves on when it is empty or the stage after it moves on.
    always_comb begin
        en[STAGES-1] = !r_v[STAGES-1] || i_dn_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_up_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Signed offset from the calibration voltage, kept as sign and magnitude.
    always_comb begin
        n_neg = i_mv < i_cal_mv;
        n_mag = n_neg ? (i_cal_mv - i_mv) : (i_mv - i_cal_mv);
    end

    // Round the 24-bit fraction away from zero, saturate, restore the sign.
    always_comb begin
        sum    = SUM_W'(r_p2) + HALF;
        ua     = sum[wlti_pkg::CUR_SHIFT +: UA_W];
        ua_sat = (ua > LIMIT) ? MAG_W'(wlti_pkg::CUR_LIMIT) : ua[MAG_W-1:0];
        n_cur  = r_neg2 ? (CUR_W'(0) - {1'b0, ua_sat}) : {1'b0, ua_sat};
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_neg0 <= n_neg;
            r_mag  <= n_mag;
        end
        if (en[1]) begin
            r_neg1 <= r_neg0;
            r_p1   <= P1_W'(r_mag) * P1_W'(i_amp_gain);
        end
        if (en[2]) begin
            r_neg2 <= r_neg1;
            r_p2   <= P2_W'(r_p1) * P2_W'(i_pump_scale);
        end
        if (en[3]) begin
            r_cur  <= n_cur;
        end
    end

    assign o_up_ready = en[0];
    assign o_dn_valid = r_v[STAGES-1];
    assign o_cur      = $signed(r_cur);

endmodule

// ===== rtl/wlti_interp.sv =====
// Table interpolation: segment search, slope multiply, reciprocal divide.
module wlti_interp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_up_valid,
    output logic                                o_up_ready,
    input  logic signed [wlti_pkg::CUR_W-1:0]   i_cur,
    input  logic                                i_newer,
    output logic                                o_dn_valid,
    input  logic                                i_dn_ready,
    output wlti_pkg::t_lam_item                 o_item
);
    localparam int STAGES  = 5;
    localparam int CUR_W   = wlti_pkg::CUR_W;
    localparam int LAM_W   = wlti_pkg::LAM_W;
    localparam int DX_W    = wlti_pkg::DX_W;
    localparam int DY_W    = wlti_pkg::DY_W;
    localparam int NUM_W   = wlti_pkg::NUM_W;
    localparam int RECIP_W = wlti_pkg::RECIP_W;
    localparam int QUO_W   = wlti_pkg::QUO_W;
    localparam int QP_W    = NUM_W + RECIP_W;
    localparam int REM_W   = DX_W + 1;
    localparam int OLD_N   = wlti_pkg::OLD_N;
    localparam int NEW_N   = wlti_pkg::NEW_N;
    localparam int OSEG_W  = $clog2(OLD_N - 1);
    localparam int OIDX_W  = $clog2(OLD_N);
    localparam int NSEG_W  = $clog2(NEW_N - 1);
    localparam int NIDX_W  = $clog2(NEW_N);

    logic [STAGES-1:0] r_v;
    logic [STAGES-1:0] en;

    // Stage payloads; the current and the flag ride along to the end.
    logic signed [CUR_W-1:0] r_cur0, r_cur1, r_cur2, r_cur3, r_cur4;
    logic                    r_flg0, r_flg1, r_flg2, r_flg3, r_flg4;
    logic [LAM_W-1:0]        r_y00, r_y01, r_y02, r_y03;
    logic [DX_W-1:0]         r_dx;
    logic [DY_W-1:0]         r_dy;
    logic [DX_W-1:0]         r_span0, r_span1, r_span2, r_span3;
    logic [RECIP_W-1:0]      r_rc0, r_rc1;
    logic [NUM_W-1:0]        r_num1, r_num2;
    logic [QP_W-1:0]         r_qp;
    logic [QUO_W-1:0]        r_q0;
    logic [REM_W-1:0]        r_rem;
    logic [LAM_W-1:0]        r_lam;

    logic [OLD_N-1:0]        ge_old;
    logic [NEW_N-1:0]        ge_new;
    logic [OSEG_W-1:0]       seg_old;
    logic [NSEG_W-1:0]       seg_new;
    logic [OIDX_W-1:0]       oi0, oi1;
    logic [NIDX_W-1:0]       ni0, ni1;
    logic signed [CUR_W-1:0] x0, x1;
    logic [LAM_W-1:0]        y0, y1;
    logic [RECIP_W-1:0]      rc;
    logic                    below, above;
    logic                    n_flag;
    logic [DX_W-1:0]         n_dx, n_span;
    logic [DY_W-1:0]         n_dy;
    logic [LAM_W-1:0]        n_y0;
    logic [RECIP_W-1:0]      n_rc;
    logic [QUO_W-1:0]        q0;
    logic [NUM_W-1:0]        back;

    // A stage moves on when it is empty or the stage after it moves on.
    always_comb begin
        en[STAGES-1] = !r_v[STAGES-1] || i_dn_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_up_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Compare against every breakpoint in parallel.
    always_comb begin
        for (int i = 0; i < OLD_N; i++) begin
            ge_old[i] = i_cur >= wlti_pkg::OLD_CUR[i];
        end
        for (int i = 0; i < NEW_N; i++) begin
            ge_new[i] = i_cur >= wlti_pkg::NEW_CUR[i];
        end
    end

    // Highest segment whose lower end lies at or below the current. The last
    // breakpoint itself falls in the final segment with a full-span offset.
    always_comb begin
        seg_old = '0;
        for (int i = 0; i < OLD_N - 1; i++) begin
            if (ge_old[i]) begin
                seg_old = OSEG_W'(i);
            end
        end
        seg_new = '0;
        for (int i = 0; i < NEW_N - 1; i++) begin
            if (ge_new[i]) begin
                seg_new = NSEG_W'(i);
            end
        end
    end

    // Fetch the segment end points from the selected table.
    always_comb begin
        oi0 = OIDX_W'(seg_old);
        oi1 = OIDX_W'(seg_old) + OIDX_W'(1);
        ni0 = NIDX_W'(seg_new);
        ni1 = NIDX_W'(seg_new) + NIDX_W'(1);
        if (i_newer) begin
            below = !ge_new[0];
            above = i_cur > wlti_pkg::NEW_CUR[NEW_N-1];
            x0    = CUR_W'(wlti_pkg::NEW_CUR[ni0]);
            x1    = CUR_W'(wlti_pkg::NEW_CUR[ni1]);
            y0    = LAM_W'(wlti_pkg::NEW_LAM[ni0]);
            y1    = LAM_W'(wlti_pkg::NEW_LAM[ni1]);
            rc    = RECIP_W'(wlti_pkg::NEW_RECIP[seg_new]);
        end else begin
            below = !ge_old[0];
            above = i_cur > wlti_pkg::OLD_CUR[OLD_N-1];
            x0    = CUR_W'(wlti_pkg::OLD_CUR[oi0]);
            x1    = CUR_W'(wlti_pkg::OLD_CUR[oi1]);
            y0    = LAM_W'(wlti_pkg::OLD_LAM[oi0]);
            y1    = LAM_W'(wlti_pkg::OLD_LAM[oi1]);
            rc    = RECIP_W'(wlti_pkg::OLD_RECIP[seg_old]);
        end
    end

    // Outside the table the slope is zeroed so the end value passes through.
    always_comb begin
        n_flag = below || above;
        if (below) begin
            n_y0   = y0;
            n_dx   = '0;
            n_dy   = '0;
            n_span = DX_W'(1);
            n_rc   = '0;
        end else if (above) begin
            n_y0   = i_newer ? LAM_W'(wlti_pkg::NEW_LAM[NEW_N-1])
                             : LAM_W'(wlti_pkg::OLD_LAM[OLD_N-1]);
            n_dx   = '0;
            n_dy   = '0;
            n_span = DX_W'(1);
            n_rc   = '0;
        end else begin
            n_y0   = y0;
            n_dx   = DX_W'(i_cur - x0);
            n_dy   = DY_W'(y1 - y0);
            n_span = DX_W'(x1 - x0);
            n_rc   = rc;
        end
    end

    // Quotient estimate is at most one low; the remainder corrects it.
    always_comb begin
        q0   = r_qp[wlti_pkg::DIV_K +: QUO_W];
        back = NUM_W'(q0) * NUM_W'(r_span2);
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_cur0  <= i_cur;
            r_flg0  <= n_flag;
            r_y00   <= n_y0;
            r_dx    <= n_dx;
            r_dy    <= n_dy;
            r_span0 <= n_span;
            r_rc0   <= n_rc;
        end
        if (en[1]) begin
            r_cur1  <= r_cur0;
            r_flg1  <= r_flg0;
            r_y01   <= r_y00;
            r_span1 <= r_span0;
            r_rc1   <= r_rc0;
            r_num1  <= NUM_W'(r_dx) * NUM_W'(r_dy) + NUM_W'(r_span0 >> 1);
        end
        if (en[2]) begin
            r_cur2  <= r_cur1;
            r_flg2  <= r_flg1;
            r_y02   <= r_y01;
            r_span2 <= r_span1;
            r_num2  <= r_num1;
            r_qp    <= QP_W'(r_num1) * QP_W'(r_rc1);
        end
        if (en[3]) begin
            r_cur3  <= r_cur2;
            r_flg3  <= r_flg2;
            r_y03   <= r_y02;
            r_span3 <= r_span2;
            r_q0    <= q0;
            r_rem   <= REM_W'(r_num2 - back);
        end
        if (en[4]) begin
            r_cur4  <= r_cur3;
            r_flg4  <= r_flg3;
            r_lam   <= r_y03 + LAM_W'(r_q0) + LAM_W'(r_rem >= REM_W'(r_span3));
        end
    end

    assign o_up_ready  = en[0];
    assign o_dn_valid  = r_v[STAGES-1];
    assign o_item.cur  = r_cur4;
    assign o_item.lam  = r_lam;
    assign o_item.flag = r_flg4;

endmodule

// ===== rtl/wlti_afr.sv =====
// Air-fuel ratio: lambda times stoichiometric ratio, divided by 1000 and saturated.
module wlti_afr (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_up_valid,
    output logic                           o_up_ready,
    input  wlti_pkg::t_lam_item            i_item,
    input  logic [wlti_pkg::STOICH_W-1:0]  i_stoich,
    output logic                           o_dn_valid,
    input  logic                           i_dn_ready,
    output wlti_pkg::t_lam_item            o_item,
    output logic [wlti_pkg::AFR_W-1:0]     o_afr
);
    localparam int STAGES = 3;
    localparam int PROD_W = wlti_pkg::LAM_W + wlti_pkg::STOICH_W;
    localparam int RCP_W  = wlti_pkg::AFR_K - $clog2(wlti_pkg::AFR_DIV) + 1;
    localparam int QP_W   = PROD_W + RCP_W;
    localparam int Q_W    = QP_W - wlti_pkg::AFR_K;
    localparam int REM_W  = $clog2(wlti_pkg::AFR_DIV) + 1;
    localparam int AFR_W  = wlti_pkg::AFR_W;

    logic [STAGES-1:0] r_v;
    logic [STAGES-1:0] en;

    wlti_pkg::t_lam_item r_it0, r_it1, r_it2;
    logic [PROD_W-1:0]   r_p0, r_p1;
    logic [QP_W-1:0]     r_qp;
    logic [AFR_W-1:0]    r_afr;

    logic [Q_W-1:0]      q0;
    logic [Q_W-1:0]      q;
    logic [REM_W-1:0]    rem;

    // A stage moves on when it is empty or the stage after it moves on.
    always_comb begin
        en[STAGES-1] = !r_v[STAGES-1] || i_dn_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_up_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Reciprocal quotient is at most one low; fix it from the remainder.
    always_comb begin
        q0  = r_qp[wlti_pkg::AFR_K +: Q_W];
        rem = REM_W'(r_p1 - PROD_W'(q0) * PROD_W'(wlti_pkg::AFR_DIV));
        q   = q0 + Q_W'(rem >= REM_W'(wlti_pkg::AFR_DIV));
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_it0 <= i_item;
            r_p0  <= PROD_W'(i_item.lam) * PROD_W'(i_stoich)
                     + PROD_W'(wlti_pkg::AFR_ROUND);
        end
        if (en[1]) begin
            r_it1 <= r_it0;
            r_p1  <= r_p0;
            r_qp  <= QP_W'(r_p0) * QP_W'(wlti_pkg::AFR_RECIP);
        end
        if (en[2]) begin
            r_it2 <= r_it1;
            r_afr <= (q > Q_W'(wlti_pkg::AFR_MAX)) ? AFR_W'(wlti_pkg::AFR_MAX)
                                                   : q[AFR_W-1:0];
        end
    end

    assign o_up_ready = en[0];
    assign o_dn_valid = r_v[STAGES-1];
    assign o_item     = r_it2;
    assign o_afr      = r_afr;

endmodule

// ===== rtl/wideband_lambda_table_interp.sv =====
// Channel   Dir  Payload                                          Handshake
// i_in      in   pump_millivolts                                  valid / ready
// o_out     out  pump_microamps, lambda_milli, afr_centi,         valid / ready
//                out_of_table
// i_cfg_*   in   register index and write data                    write enable
//
// One sample is taken every cycle while the output is not stalled; each result passes
// through the current path (4 stages around two cascaded multiplies), the interpolator
// (5 stages around the reciprocal divide) and the ratio (3).
// Reset is synchronous and active low: it empties every stage and loads the
// register defaults. Every stage holds its own valid bit, so a stall at the
// output fills empty stages before input ready falls, and nothing is lost.
module wideband_lambda_table_interp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    wlti_in_if.sink                              i_in,
    wlti_out_if.source                           o_out,
    input  logic                                 i_cfg_we,
    input  logic [wlti_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [wlti_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    wlti_pkg::t_cfg                     r_cfg;

    logic                               cur_valid, cur_ready;
    logic signed [wlti_pkg::CUR_W-1:0]  cur;
    logic                               lam_valid, lam_ready;
    wlti_pkg::t_lam_item                lam_item;
    wlti_pkg::t_lam_item                out_item;
    logic [wlti_pkg::AFR_W-1:0]         out_afr;

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cal_mv     <= wlti_pkg::CAL_MV_RST;
            r_cfg.amp_gain   <= wlti_pkg::AMP_GAIN_RST;
            r_cfg.pump_scale <= wlti_pkg::PUMP_SCALE_RST;
            r_cfg.newer      <= wlti_pkg::NEWER_RST;
            r_cfg.stoich     <= wlti_pkg::STOICH_RST;
        end else if (i_cfg_we) begin
            unique case (wlti_pkg::t_cfg_reg'(i_cfg_idx))
                wlti_pkg::REG_CAL_MV: begin
                    r_cfg.cal_mv <= i_cfg_data[wlti_pkg::MV_W-1:0];
                end
                wlti_pkg::REG_AMP_GAIN: begin
                    r_cfg.amp_gain <= i_cfg_data[wlti_pkg::GAIN_W-1:0];
                end
                wlti_pkg::REG_PUMP_SCALE: begin
                    r_cfg.pump_scale <= i_cfg_data[wlti_pkg::SCALE_W-1:0];
                end
                wlti_pkg::REG_NEWER: begin
                    r_cfg.newer <= i_cfg_data[0];
                end
                wlti_pkg::REG_STOICH: begin
                    r_cfg.stoich <= i_cfg_data[wlti_pkg::STOICH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Pump current from the sample voltage.
    wlti_current u_current (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_up_valid   (i_in.valid),
        .o_up_ready   (i_in.ready),
        .i_mv         (i_in.pump_millivolts),
        .i_cal_mv     (r_cfg.cal_mv),
        .i_amp_gain   (r_cfg.amp_gain),
        .i_pump_scale (r_cfg.pump_scale),
        .o_dn_valid   (cur_valid),
        .i_dn_ready   (cur_ready),
        .o_cur        (cur)
    );

    // Lambda from the selected breakpoint table.
    wlti_interp u_interp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (cur_valid),
        .o_up_ready (cur_ready),
        .i_cur      (cur),
        .i_newer    (r_cfg.newer),
        .o_dn_valid (lam_valid),
        .i_dn_ready (lam_ready),
        .o_item     (lam_item)
    );

    // Air-fuel ratio and the output register.
    wlti_afr u_afr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (lam_valid),
        .o_up_ready (lam_ready),
        .i_item     (lam_item),
        .i_stoich   (r_cfg.stoich),
        .o_dn_valid (o_out.valid),
        .i_dn_ready (o_out.ready),
        .o_item     (out_item),
        .o_afr      (out_afr)
    );

    assign o_out.pump_microamps = out_item.cur;
    assign o_out.lambda_milli   = out_item.lam;
    assign o_out.afr_centi      = out_afr;
    assign o_out.out_of_table   = out_item.flag;

    // With no result waiting, every stage can move, so input ready is high.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input not ready although the pipeline is drained");

    // The current is saturated before the table is consulted.
    a_current_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.pump_microamps >= -wlti_pkg::CUR_LIMIT &&
                         o_out.pump_microamps <= wlti_pkg::CUR_LIMIT))
        else $error("pump current outside saturation limits");

    // A clamped transaction carries one of the table end values.
    a_clamp_end_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.out_of_table) |->
            (o_out.lambda_milli == wlti_pkg::OLD_LAM[0] ||
             o_out.lambda_milli == wlti_pkg::OLD_LAM[wlti_pkg::OLD_N-1] ||
             o_out.lambda_milli == wlti_pkg::NEW_LAM[0] ||
             o_out.lambda_milli == wlti_pkg::NEW_LAM[wlti_pkg::NEW_N-1]))
        else $error("clamped lambda is not a table end value");

    // Interpolation never leaves the span of the tables.
    a_lambda_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.lambda_milli >= wlti_pkg::NEW_LAM[0] &&
                         o_out.lambda_milli <= wlti_pkg::NEW_LAM[wlti_pkg::NEW_N-1]))
        else $error("interpolated lambda outside table span");

endmodule

// ===== verif/tb_wideband_lambda_table_interp.sv =====
module tb_wideband_lambda_table_interp;

    // Widths taken from the package.
    localparam int MV_W       = wlti_pkg::MV_W;
    localparam int CUR_W      = wlti_pkg::CUR_W;
    localparam int LAM_W      = wlti_pkg::LAM_W;
    localparam int AFR_W      = wlti_pkg::AFR_W;
    localparam int GAIN_W     = wlti_pkg::GAIN_W;
    localparam int SCALE_W    = wlti_pkg::SCALE_W;
    localparam int STOICH_W   = wlti_pkg::STOICH_W;
    localparam int CFG_IDX_W  = wlti_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = wlti_pkg::CFG_DATA_W;

    // Run limits and traffic shaping.
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_CYCLES     = 80;
    localparam int RANDOM_PHASES   = 12;
    localparam int SAMPLES_PER_PH  = 62;
    localparam int DRAIN_CYCLES    = 16;
    localparam int FIRST_SPARE_IDX = int'(wlti_pkg::REG_STOICH) + 1;

    // Gain and scale whose product is exactly 2^24, so current equals mV offset.
    localparam int UNIT_GAIN  = 32768;
    localparam int UNIT_SCALE = 512;
    localparam int UNIT_CAL   = 2500;

    // One expected reading, laid out as the result channel carries it.
    typedef struct packed {
        logic signed [CUR_W-1:0] cur;
        logic [LAM_W-1:0]        lam;
        logic [AFR_W-1:0]        afr;
        logic                    flag;
    } t_reading;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    wlti_in_if  in_if ();
    wlti_out_if out_if ();

    wideband_lambda_table_interp u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Predictor copy of the configuration registers.
    logic [MV_W-1:0]     model_cal    = wlti_pkg::CAL_MV_RST;
    logic [GAIN_W-1:0]   model_gain   = wlti_pkg::AMP_GAIN_RST;
    logic [SCALE_W-1:0]  model_scale  = wlti_pkg::PUMP_SCALE_RST;
    logic                model_newer  = wlti_pkg::NEWER_RST;
    logic [STOICH_W-1:0] model_stoich = wlti_pkg::STOICH_RST;

    logic [MV_W-1:0] pending_mv [$];
    t_reading        reading_q [$];
    t_reading        want;

    int cycle_count       = 0;
    int err_count         = 0;
    int samples_queued    = 0;
    int samples_offered   = 0;
    int samples_taken     = 0;
    int readings_checked  = 0;
    int tx_idle_pct       = 0;
    int rx_idle_pct       = 0;
    int hold_req          = 0;
    int hold_ack          = 0;
    int hold_left         = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Breakpoints of whichever table is selected.
    function automatic int bp_cur(int k);
        return model_newer ? wlti_pkg::NEW_CUR[k] : wlti_pkg::OLD_CUR[k];
    endfunction

    function automatic int bp_lam(int k);
        return model_newer ? wlti_pkg::NEW_LAM[k] : wlti_pkg::OLD_LAM[k];
    endfunction

    // Pump current, interpolated lambda and air-fuel ratio for one sample.
    function automatic t_reading predict_reading(logic [MV_W-1:0] mv);
        t_reading          r;
        logic              neg;
        logic              flag;
        longint unsigned   mag;
        longint unsigned   ua;
        int                cur;
        int                n;
        int unsigned       lam;
        int unsigned       afr;
        int unsigned       dx;
        int unsigned       dy;
        int unsigned       span;
        neg = (mv < model_cal);
        mag = neg ? model_cal - mv : mv - model_cal;
        ua  = (mag * model_gain * model_scale + (64'd1 << (wlti_pkg::CUR_SHIFT - 1)))
              >> wlti_pkg::CUR_SHIFT;
        if (ua > wlti_pkg::CUR_LIMIT) begin
            ua = wlti_pkg::CUR_LIMIT;
        end
        cur  = neg ? -int'(ua) : int'(ua);
        n    = model_newer ? wlti_pkg::NEW_N : wlti_pkg::OLD_N;
        flag = 1'b0;
        lam  = bp_lam(n - 1);
        if (cur < bp_cur(0)) begin
            flag = 1'b1;
            lam  = bp_lam(0);
        end else if (cur > bp_cur(n - 1)) begin
            flag = 1'b1;
        end else begin
            for (int i = 0; i < n - 1; i++) begin
                if (cur >= bp_cur(i) && cur < bp_cur(i + 1)) begin
                    dx   = cur - bp_cur(i);
                    span = bp_cur(i + 1) - bp_cur(i);
                    dy   = bp_lam(i + 1) - bp_lam(i);
                    lam  = bp_lam(i) + (dx * dy + span / 2) / span;
                end
            end
        end
        afr = (lam * model_stoich + wlti_pkg::AFR_ROUND) / wlti_pkg::AFR_DIV;
        if (afr > wlti_pkg::AFR_MAX) begin
            afr = wlti_pkg::AFR_MAX;
        end
        r.cur  = CUR_W'(cur);
        r.lam  = LAM_W'(lam);
        r.afr  = AFR_W'(afr);
        r.flag = flag;
        return r;
    endfunction

    // A voltage whose current lands within a couple of steps of a breakpoint.
    function automatic logic [MV_W-1:0] near_breakpoint_mv();
        int     k;
        longint gs;
        longint t;
        k  = $urandom_range(0, (model_newer ? wlti_pkg::NEW_N : wlti_pkg::OLD_N) - 1);
        gs = longint'(model_gain) * longint'(model_scale);
        if (gs == 0) begin
            return MV_W'($urandom);
        end
        t = longint'(model_cal) + (longint'(bp_cur(k)) * 64'sd16777216) / gs
            + longint'($urandom_range(0, 4)) - 2;
        if (t < 0) begin
            t = 0;
        end else if (t > (1 << MV_W) - 1) begin
            t = (1 << MV_W) - 1;
        end
        return MV_W'(t);
    endfunction

    task automatic log_mismatch(string what);
        err_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    task automatic push_sample(logic [MV_W-1:0] mv);
        pending_mv.push_back(mv);
        samples_queued++;
    endtask

    task automatic set_traffic(int tx_pct, int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    // Every reading of every queued sample has been checked.
    task automatic wait_drained();
        do @(negedge i_clk); while (readings_checked != samples_queued);
    endtask

    // One register write; the predictor copy follows it, masked to width.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            wlti_pkg::REG_CAL_MV:     model_cal    = data[MV_W-1:0];
            wlti_pkg::REG_AMP_GAIN:   model_gain   = data[GAIN_W-1:0];
            wlti_pkg::REG_PUMP_SCALE: model_scale  = data[SCALE_W-1:0];
            wlti_pkg::REG_NEWER:      model_newer  = data[0];
            wlti_pkg::REG_STOICH:     model_stoich = data[STOICH_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        i_cfg_data <= CFG_DATA_W'($urandom);
    endtask

    // Writes all five registers; unused upper data bits carry noise.
    task automatic set_config(int cal, int gain, int scale, int newer, int stoich);
        write_reg(wlti_pkg::REG_CAL_MV, {3'($urandom), MV_W'(cal)});
        write_reg(wlti_pkg::REG_AMP_GAIN, GAIN_W'(gain));
        write_reg(wlti_pkg::REG_PUMP_SCALE, SCALE_W'(scale));
        write_reg(wlti_pkg::REG_NEWER, {15'($urandom), 1'(newer)});
        write_reg(wlti_pkg::REG_STOICH, {5'($urandom), STOICH_W'(stoich)});
    endtask

    task automatic random_config();
        int cal;
        int gain;
        int scale;
        int stoich;
        case ($urandom_range(0, 3))
            0: begin
                gain  = UNIT_GAIN;
                scale = UNIT_SCALE;
                cal   = $urandom_range(1000, 4000);
            end
            1: begin
                gain  = wlti_pkg::AMP_GAIN_RST;
                scale = wlti_pkg::PUMP_SCALE_RST;
                cal   = $urandom_range(0, 5000);
            end
            2: begin
                gain  = $urandom_range(0, 65535);
                scale = $urandom_range(0, 65535);
                cal   = $urandom_range(0, (1 << MV_W) - 1);
            end
            default: begin
                gain  = $urandom_range(0, 1) ? 65535 : 0;
                scale = $urandom_range(0, 1) ? 65535 : 0;
                cal   = $urandom_range(0, 1) ? (1 << MV_W) - 1 : 0;
            end
        endcase
        case ($urandom_range(0, 5))
            0:       stoich = 0;
            1:       stoich = 500;
            2:       stoich = 2000;
            3:       stoich = (1 << STOICH_W) - 1;
            4:       stoich = wlti_pkg::STOICH_RST;
            default: stoich = $urandom_range(500, 2000);
        endcase
        set_config(cal, gain, scale, $urandom_range(0, 1), stoich);
        // Writes to indexes past the register list must change nothing.
        if ($urandom_range(0, 2) == 0) begin
            write_reg(CFG_IDX_W'(FIRST_SPARE_IDX + $urandom_range(0, 2)),
                      CFG_DATA_W'($urandom));
        end
    endtask

    // Cycle counter and overall timeout.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Sample driver: offers queued voltages, holding each until it is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (in_if.valid && samples_taken != samples_offered) begin
            // Current transaction still waiting for ready.
        end else if (pending_mv.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
            in_if.valid           <= 1'b1;
            in_if.pump_millivolts <= pending_mv.pop_front();
            samples_offered++;
        end else begin
            in_if.valid           <= 1'b0;
            in_if.pump_millivolts <= MV_W'($urandom);
        end
    end

    // Result receiver: random stalls, plus a long hold-off when requested.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (hold_req != hold_ack) begin
                hold_left = HOLD_CYCLES;
                hold_ack  = hold_req;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Each accepted sample transaction queues its expected reading.
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) begin
            reading_q.push_back(predict_reading(in_if.pump_millivolts));
            samples_taken++;
        end
    end

    // Each accepted result transaction is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (reading_q.size() == 0) begin
                log_mismatch("result transaction with no sample outstanding");
            end else begin
                want = reading_q.pop_front();
                if (out_if.pump_microamps !== want.cur) begin
                    log_mismatch($sformatf("pump_microamps %0d, expected %0d",
                                           out_if.pump_microamps, want.cur));
                end
                if (out_if.lambda_milli !== want.lam) begin
                    log_mismatch($sformatf("lambda_milli %0d, expected %0d",
                                           out_if.lambda_milli, want.lam));
                end
                if (out_if.afr_centi !== want.afr) begin
                    log_mismatch($sformatf("afr_centi %0d, expected %0d",
                                           out_if.afr_centi, want.afr));
                end
                if (out_if.out_of_table !== want.flag) begin
                    log_mismatch($sformatf("out_of_table %0b, expected %0b",
                                           out_if.out_of_table, want.flag));
                end
                readings_checked++;
            end
        end
    end

    // Stimulus sequence.
    initial begin
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = '0;
        i_cfg_data            = '0;
        in_if.valid           = 1'b0;
        in_if.pump_millivolts = '0;
        out_if.ready          = 1'b0;
        set_traffic(25, 64);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Register defaults: voltage extremes and the calibration point.
        push_sample(MV_W'(0));
        push_sample(MV_W'(wlti_pkg::CAL_MV_RST - 1));
        push_sample(wlti_pkg::CAL_MV_RST);
        push_sample(MV_W'(5000));
        push_sample(MV_W'((1 << MV_W) - 1));
        wait_drained();

        // Unit gain on the older table: both ends, exact last point, mid segment.
        set_config(UNIT_CAL, UNIT_GAIN, UNIT_SCALE, 0, wlti_pkg::STOICH_RST);
        push_sample(MV_W'(UNIT_CAL + wlti_pkg::OLD_CUR[0] - 1));
        push_sample(MV_W'(UNIT_CAL + wlti_pkg::OLD_CUR[0]));
        push_sample(MV_W'(UNIT_CAL));
        push_sample(MV_W'(UNIT_CAL + wlti_pkg::OLD_CUR[wlti_pkg::OLD_N-1] - 1));
        push_sample(MV_W'(UNIT_CAL + wlti_pkg::OLD_CUR[wlti_pkg::OLD_N-1]));
        push_sample(MV_W'(UNIT_CAL + wlti_pkg::OLD_CUR[wlti_pkg::OLD_N-1] + 1));
        push_sample(MV_W'(UNIT_CAL + 949));
        wait_drained();

        // Same on the newer table, including the steep top segments.
        set_config(UNIT_CAL, UNIT_GAIN, UNIT_SCALE, 1, 2000);
        push_sample(MV_W'(UNIT_CAL + wlti_pkg::NEW_CUR[0] - 1));
        push_sample(MV_W'(UNIT_CAL + wlti_pkg::NEW_CUR[0]));
        push_sample(MV_W'(UNIT_CAL + 14));
        push_sample(MV_W'(UNIT_CAL + 2100));
        push_sample(MV_W'(UNIT_CAL + wlti_pkg::NEW_CUR[wlti_pkg::NEW_N-1] - 1));
        push_sample(MV_W'(UNIT_CAL + wlti_pkg::NEW_CUR[wlti_pkg::NEW_N-1]));
        push_sample(MV_W'(UNIT_CAL + wlti_pkg::NEW_CUR[wlti_pkg::NEW_N-1] + 1));
        wait_drained();

        // Maximum gain: current saturates both ways; widest stoichiometric value.
        set_config(0, 65535, 65535, 1, (1 << STOICH_W) - 1);
        push_sample(MV_W'(0));
        push_sample(MV_W'((1 << MV_W) - 1));
        wait_drained();
        set_config((1 << MV_W) - 1, 65535, 65535, 0, 500);
        push_sample(MV_W'(0));
        push_sample(MV_W'((1 << MV_W) - 1));
        wait_drained();

        // Random phases, each under its own configuration.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph < RANDOM_PHASES / 3) begin
                set_traffic(25, 64);
            end else if (ph < 2 * RANDOM_PHASES / 3) begin
                set_traffic(64, 25);
            end else begin
                set_traffic(0, 0);
            end
            random_config();
            // Long receiver hold-off so the pipeline fills and input ready falls.
            if (ph == RANDOM_PHASES / 3 || ph == 2 * RANDOM_PHASES / 3) begin
                hold_req++;
            end
            for (int s = 0; s < SAMPLES_PER_PH; s++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: push_sample(near_breakpoint_mv());
                    4, 5, 6, 7: push_sample(MV_W'($urandom));
                    default:    push_sample(MV_W'($urandom_range(0, 5000)));
                endcase
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (reading_q.size() != 0) begin
            log_mismatch($sformatf("%0d readings never arrived", reading_q.size()));
        end
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== wideband_lambda_table_interp.f =====
rtl/wlti_pkg.sv
rtl/wlti_in_if.sv
rtl/wlti_out_if.sv
rtl/wlti_current.sv
rtl/wlti_interp.sv
rtl/wlti_afr.sv
rtl/wideband_lambda_table_interp.sv
verif/tb_wideband_lambda_table_interp.sv
